[src/bctc_pkg.sv]
package bctc_pkg;

    // history and datapath sizes
    localparam int HISTORY_DEPTH = 5;
    localparam int HIST_CELLS    = HISTORY_DEPTH - 1;
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 20;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int VOLT_W     = 14;
    localparam int PCT_W      = 7;
    localparam int FULL_THR_W = 14;
    localparam int TREND_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [VOLT_W-1:0] VMAX_MV        = 14'd16383;
    localparam logic [VOLT_W-1:0] PCT_LOW_MV     = 14'd3000;
    localparam logic [VOLT_W-1:0] PCT_HIGH_MV    = 14'd4200;
    localparam logic [VOLT_W-1:0] STABLE_FULL_MV = 14'd4000;
    localparam logic [PCT_W-1:0]  PCT_MAX        = 7'd100;

    // reciprocal of three in q11, exact for quotients below 300
    localparam logic [9:0] RECIP3_Q11 = 10'd683;

    localparam logic [GAIN_W-1:0]     GAIN_RESET     = 20'd105625;
    localparam logic [FULL_THR_W-1:0] FULL_THR_RESET = 14'd4150;
    localparam logic [TREND_W-1:0]    TREND_RESET    = 12'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN      = 2'd0,
        CFG_FULL_THR  = 2'd1,
        CFG_TREND_THR = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CS_UNKNOWN     = 2'd0,
        CS_CHARGING    = 2'd1,
        CS_FULL        = 2'd2,
        CS_DISCHARGING = 2'd3
    } t_charge_state;

endpackage

[src/battery_charge_trend_classifier_core.sv]
// a result is valid once its item has passed the stage one and stage two registers
// throughput: one item per cycle unless the output stalls; stage one holds the sample-by-gain product,
// stage two classifies against the row of history cells and holds the result
// an item is taken while a finished result waits, as long as stage one is free
// reset (synchronous, active low) clears the pipeline, fill count and charge
// state and restores the register defaults; history cells are not cleared
module battery_charge_trend_classifier_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bctc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bctc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bctc_pkg::SAMPLE_W-1:0]    i_adc_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bctc_pkg::VOLT_W-1:0]      o_voltage_mv,
    output logic [bctc_pkg::PCT_W-1:0]       o_percent,
    output logic [1:0]                       o_charge_state,
    output logic                             o_state_changed
);

    logic [bctc_pkg::GAIN_W-1:0]     r_gain;
    logic [bctc_pkg::FULL_THR_W-1:0] r_full_thr;
    logic [bctc_pkg::TREND_W-1:0]    r_trend_thr;

    logic                            en1;
    logic                            en2;
    logic                            ld2;
    logic                            v1;
    logic [bctc_pkg::PROD_W-1:0]     prod;

    logic                            r_v2;
    logic [bctc_pkg::VOLT_W-1:0]     r_volt;
    logic [bctc_pkg::PCT_W-1:0]      r_pct;
    logic                            r_changed;
    logic [bctc_pkg::FILL_W-1:0]     r_fill;
    logic [bctc_pkg::FILL_W-1:0]     n_fill;
    bctc_pkg::t_charge_state         r_state;
    bctc_pkg::t_charge_state         n_state;
    bctc_pkg::t_charge_state         cls_state;
    logic                            n_changed;

    logic [bctc_pkg::VOLT_W-1:0]     hist [bctc_pkg::HIST_CELLS];
    logic [15:0]                     prod_hi;
    logic [bctc_pkg::VOLT_W-1:0]     volt;
    logic [10:0]                     pct_off;
    logic [17:0]                     pct_prod;
    logic [bctc_pkg::PCT_W-1:0]      pct;
    logic [bctc_pkg::VOLT_W:0]       sum_new;
    logic [bctc_pkg::VOLT_W:0]       sum_old;
    logic signed [16:0]              diff;
    logic signed [16:0]              mag;
    logic signed [16:0]              t2;
    logic                            at_full;
    logic                            filled;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= bctc_pkg::GAIN_RESET;
            r_full_thr  <= bctc_pkg::FULL_THR_RESET;
            r_trend_thr <= bctc_pkg::TREND_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bctc_pkg::CFG_GAIN:      r_gain      <= i_cfg_data;
                bctc_pkg::CFG_FULL_THR:  r_full_thr  <= i_cfg_data[bctc_pkg::FULL_THR_W-1:0];
                bctc_pkg::CFG_TREND_THR: r_trend_thr <= i_cfg_data[bctc_pkg::TREND_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow
    assign en2        = !r_v2 || i_out_ready;
    assign en1        = !v1 || en2;
    assign ld2        = en2 && v1;
    assign o_in_ready = en1;

    bctc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en1),
        .i_valid  (i_in_valid),
        .i_sample (i_adc_sample),
        .i_gain   (r_gain),
        .o_valid  (v1),
        .o_prod   (prod)
    );

    // scale and saturate
    assign prod_hi = prod[bctc_pkg::PROD_W-1:16];
    assign volt    = (prod_hi > 16'(bctc_pkg::VMAX_MV)) ? bctc_pkg::VMAX_MV
                                                        : prod_hi[bctc_pkg::VOLT_W-1:0];

    // percent: offset / 12 as (offset / 4) / 3
    assign pct_off  = 11'(volt - bctc_pkg::PCT_LOW_MV);
    assign pct_prod = 18'(pct_off[10:2]) * 18'(bctc_pkg::RECIP3_Q11);

    always_comb begin
        if (volt >= bctc_pkg::PCT_HIGH_MV) begin
            pct = bctc_pkg::PCT_MAX;
        end else if (volt <= bctc_pkg::PCT_LOW_MV) begin
            pct = '0;
        end else begin
            pct = pct_prod[17:11];
        end
    end

    // row of history cells, cell 0 holds the previous item's voltage
    genvar g;
    generate
        for (g = 0; g < bctc_pkg::HIST_CELLS; g++) begin : g_hist
            if (g == 0) begin : g_head
                bctc_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (ld2),
                    .i_volt  (volt),
                    .o_volt  (hist[g])
                );
            end else begin : g_body
                bctc_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (ld2),
                    .i_volt  (hist[g-1]),
                    .o_volt  (hist[g])
                );
            end
        end
    endgenerate

    // trend over the window that includes the current item
    assign sum_new = {1'b0, volt} + {1'b0, hist[0]};
    assign sum_old = {1'b0, hist[bctc_pkg::HIST_CELLS-1]} +
                     {1'b0, hist[bctc_pkg::HIST_CELLS-2]};
    assign diff    = $signed({2'b00, sum_new}) - $signed({2'b00, sum_old});
    assign mag     = diff[16] ? -diff : diff;
    assign t2      = $signed({4'b0000, r_trend_thr, 1'b0});
    assign at_full = volt >= r_full_thr;

    always_comb begin
        priority if (at_full && (mag < t2)) begin
            cls_state = bctc_pkg::CS_FULL;
        end else if (diff > t2) begin
            cls_state = bctc_pkg::CS_CHARGING;
        end else if (diff < -t2) begin
            cls_state = bctc_pkg::CS_DISCHARGING;
        end else if (at_full) begin
            cls_state = bctc_pkg::CS_FULL;
        end else if (volt > bctc_pkg::STABLE_FULL_MV) begin
            cls_state = bctc_pkg::CS_FULL;
        end else begin
            cls_state = bctc_pkg::CS_DISCHARGING;
        end
    end

    assign filled = r_fill == bctc_pkg::FILL_W'(bctc_pkg::HISTORY_DEPTH);

    always_comb begin
        n_fill    = r_fill;
        n_state   = r_state;
        n_changed = 1'b0;
        if (!filled) begin
            n_fill = r_fill + 1'b1;
        end else if (cls_state != r_state) begin
            n_state   = cls_state;
            n_changed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2    <= 1'b0;
            r_fill  <= '0;
            r_state <= bctc_pkg::CS_UNKNOWN;
        end else begin
            if (en2) begin
                r_v2 <= v1;
            end
            if (ld2) begin
                r_fill  <= n_fill;
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_volt    <= volt;
            r_pct     <= pct;
            r_changed <= n_changed;
        end
    end

    assign o_out_valid     = r_v2;
    assign o_voltage_mv    = r_volt;
    assign o_percent       = r_pct;
    assign o_charge_state  = r_state;
    assign o_state_changed = r_changed;

endmodule

[src/bctc_cell.sv]
module bctc_cell (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic [bctc_pkg::VOLT_W-1:0]  i_volt,
    output logic [bctc_pkg::VOLT_W-1:0]  o_volt
);

    logic [bctc_pkg::VOLT_W-1:0] r_volt;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_volt <= i_volt;
        end
    end

    assign o_volt = r_volt;

endmodule

[src/bctc_front.sv]
module bctc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [bctc_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [bctc_pkg::GAIN_W-1:0]    i_gain,
    output logic                           o_valid,
    output logic [bctc_pkg::PROD_W-1:0]    o_prod
);

    logic                          r_valid;
    logic [bctc_pkg::PROD_W-1:0]   r_prod;
    logic [bctc_pkg::PROD_W-1:0]   n_prod;

    assign n_prod = bctc_pkg::PROD_W'(i_sample) * bctc_pkg::PROD_W'(i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule
